### hw/rtl/pva_pkg.sv
// Package for the polyphonic voice allocator.
// Holds the sequencer state type, opcode, message and result codes, and defaults.
// No dependencies.
`default_nettype none
package pva_pkg;

  localparam int NOTE_SLOTS_DEF = 16;
  localparam int VOICES_DEF     = 4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK, ST_ALLOFF, ST_OFF_SCAN, ST_MOVE, ST_ON_DUP,
    ST_ON_FREE, ST_SWEEP, ST_BEND, ST_CTRL, ST_DONE
  } pva_state_t;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_MIDI   = 2'd1;
  localparam logic [1:0] OP_ALLOFF = 2'd2;

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_CTRL     = 4'hB;
  localparam logic [3:0] MSG_BEND     = 4'hE;

  localparam logic [6:0] CC_VOLUME     = 7'h07;
  localparam logic [6:0] CC_RESET_A    = 7'h78;
  localparam logic [6:0] CC_RESET_B    = 7'h79;
  localparam logic [6:0] CC_RESET_C    = 7'h7B;
  localparam logic [6:0] CC_RESET_D    = 7'h7C;

  localparam logic [1:0] KIND_VOICE   = 2'd0;
  localparam logic [1:0] KIND_CHANNEL = 2'd1;
  localparam logic [1:0] KIND_TIMERS  = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam logic [1:0] CFG_LOWEST  = 2'd0;
  localparam logic [1:0] CFG_HIGHEST = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [13:0] BEND_CENTER = 14'h2000;

endpackage
`default_nettype wire

### hw/rtl/polyphonic_voice_allocator.sv
// Top level of the polyphonic voice allocator: slot table, channel table and sequencer.
// Depends on pva_pkg.
//
// An item is taken when start is high and busy is low. Busy then stays high until the cycle
// in which the final done result is on the result ports, and a new item may be taken in
// that same cycle. One slot of the table is examined per clock by a single sequencer. At
// most one result appears per cycle on out_valid and must be taken in that cycle, since the
// receiver cannot stall; the last one of each transaction has out_last set.
`default_nettype none
module polyphonic_voice_allocator
  import pva_pkg::*;
#(
  parameter int NOTE_SLOTS = NOTE_SLOTS_DEF,
  parameter int VOICES     = VOICES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [7:0]         in_status_byte,
  input  wire logic [6:0]         in_data_one,
  input  wire logic [6:0]         in_data_two,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic [3:0]              out_voice_index,
  output logic                    out_voice_active,
  output logic [6:0]              out_note_number,
  output logic [6:0]              out_velocity,
  output logic [3:0]              out_channel,
  output logic [6:0]              out_volume,
  output logic signed [13:0]      out_pitch_bend,
  output logic                    out_last
);

  localparam int S  = (VOICES < NOTE_SLOTS) ? VOICES : NOTE_SLOTS;
  localparam int IW = $clog2(NOTE_SLOTS);
  localparam bit HAS_OVF = (S < NOTE_SLOTS);
  localparam logic [IW-1:0] LAST_I  = IW'(NOTE_SLOTS - 1);
  localparam logic [IW-1:0] FIRST_J = IW'(S % NOTE_SLOTS);
  localparam logic [IW-1:0] BEND_I  = IW'(S - 1);
  localparam logic [IW:0]   SND     = (IW + 1)'(S);

  pva_state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt, jdx_r, jdx_nxt;
  logic sweep_r, sweep_nxt, hit_r, hit_nxt;

  logic [6:0]  lowest_r, highest_r;
  logic [15:0] limit_r;
  logic [3:0]  ch_r;
  logic [6:0]  d1_r, d2_r;

  logic        play_r  [NOTE_SLOTS];
  logic [6:0]  note_r  [NOTE_SLOTS];
  logic [6:0]  vel_r   [NOTE_SLOTS];
  logic [3:0]  sch_r   [NOTE_SLOTS];
  logic [15:0] age_r   [NOTE_SLOTS];
  logic [6:0]  vol_r   [16];
  logic [13:0] bend_r  [16];

  logic accept;
  logic [3:0] msg;
  logic p, pj, idx_last, j_last, idx_snd;
  logic off_hit, dup_hit, tmo_hit, bend_cur, free_ev, in_range, reset_cc;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign msg      = in_status_byte[7:4];
  assign p        = play_r[idx_r];
  assign pj       = play_r[jdx_r];
  assign idx_last = (idx_r == LAST_I);
  assign j_last   = (jdx_r == LAST_I);
  assign idx_snd  = ({1'b0, idx_r} < SND);
  assign off_hit  = p && (note_r[idx_r] == d1_r) && (sch_r[idx_r] == ch_r);
  assign dup_hit  = p && (note_r[idx_r] == d1_r);
  assign tmo_hit  = p && (age_r[idx_r] >= limit_r);
  assign bend_cur = p && (sch_r[idx_r] == ch_r);
  assign free_ev  = ((state_r == ST_OFF_SCAN) && off_hit) ||
                    ((state_r == ST_SWEEP) && tmo_hit);
  assign in_range = (in_data_one >= lowest_r) && (in_data_one <= highest_r);
  assign reset_cc = (d1_r == CC_RESET_A) || (d1_r == CC_RESET_B) ||
                    (d1_r == CC_RESET_C) || (d1_r == CC_RESET_D);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    jdx_nxt   = jdx_r;
    sweep_nxt = sweep_r;
    hit_nxt   = hit_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt   = '0;
        sweep_nxt = 1'b0;
        hit_nxt   = 1'b0;
        if (accept) begin
          case (in_opcode)
            OP_TICK:   state_nxt = ST_TICK;
            OP_ALLOFF: state_nxt = ST_ALLOFF;
            OP_MIDI: begin
              case (msg)
                MSG_NOTE_ON: begin
                  if (in_data_two == 7'd0) state_nxt = ST_OFF_SCAN;
                  else if (in_range)       state_nxt = ST_ON_DUP;
                  else                     state_nxt = ST_DONE;
                end
                MSG_NOTE_OFF: state_nxt = ST_OFF_SCAN;
                MSG_CTRL:     state_nxt = ST_CTRL;
                MSG_BEND:     state_nxt = ST_BEND;
                default:      state_nxt = ST_DONE;
              endcase
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_TICK, ST_ALLOFF: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_last) state_nxt = ST_DONE;
      end
      ST_OFF_SCAN, ST_SWEEP: begin
        if (free_ev && idx_snd && HAS_OVF) begin
          state_nxt = ST_MOVE;
          jdx_nxt   = FIRST_J;
        end else if (idx_last) begin
          state_nxt = ST_DONE;
        end else if (free_ev && !sweep_r) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_MOVE: begin
        jdx_nxt = jdx_r + 1'b1;
        if (pj || j_last) begin
          if (sweep_r && !idx_last) begin
            state_nxt = ST_SWEEP;
            idx_nxt   = idx_r + 1'b1;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ON_DUP: begin
        idx_nxt = idx_r + 1'b1;
        if (dup_hit) begin
          state_nxt = ST_DONE;
        end else if (idx_last) begin
          state_nxt = ST_ON_FREE;
          idx_nxt   = '0;
        end
      end
      ST_ON_FREE: begin
        idx_nxt = idx_r + 1'b1;
        if (!p || idx_last) begin
          state_nxt = ST_SWEEP;
          idx_nxt   = '0;
          sweep_nxt = 1'b1;
        end
      end
      ST_BEND: begin
        idx_nxt = idx_r + 1'b1;
        hit_nxt = hit_r || bend_cur;
        if (idx_r == BEND_I) state_nxt = ST_DONE;
      end
      ST_CTRL: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic       e_valid, e_act, e_last, e_vol_own;
  logic [1:0] e_kind;
  logic [IW-1:0] e_vi;
  logic [6:0] e_note, e_vel, e_vol_val;
  logic [3:0] e_ch;
  logic       e_chan_only;

  always_comb begin
    e_valid     = 1'b0;
    e_kind      = KIND_VOICE;
    e_vi        = idx_r;
    e_act       = 1'b0;
    e_note      = note_r[idx_r];
    e_vel       = vel_r[idx_r];
    e_ch        = sch_r[idx_r];
    e_last      = 1'b0;
    e_vol_own   = 1'b0;
    e_vol_val   = d2_r;
    e_chan_only = 1'b0;
    unique case (state_r)
      ST_ALLOFF:   e_valid = p && idx_snd;
      ST_OFF_SCAN, ST_SWEEP: e_valid = free_ev && idx_snd;
      ST_MOVE: begin
        e_valid = pj;
        e_act   = 1'b1;
        e_note  = note_r[jdx_r];
        e_vel   = vel_r[jdx_r];
        e_ch    = sch_r[jdx_r];
      end
      ST_ON_FREE: begin
        e_valid = !p && idx_snd;
        e_act   = 1'b1;
        e_note  = d1_r;
        e_vel   = d2_r;
        e_ch    = ch_r;
      end
      ST_BEND: begin
        e_valid     = (idx_r == BEND_I) && (hit_r || bend_cur);
        e_kind      = KIND_CHANNEL;
        e_ch        = ch_r;
        e_chan_only = 1'b1;
      end
      ST_CTRL: begin
        e_valid     = reset_cc || (d1_r == CC_VOLUME);
        e_kind      = reset_cc ? KIND_TIMERS : KIND_CHANNEL;
        e_vol_own   = (d1_r == CC_VOLUME);
        e_ch        = ch_r;
        e_chan_only = 1'b1;
      end
      ST_DONE: begin
        e_valid = 1'b1;
        e_kind  = KIND_DONE;
        e_last  = 1'b1;
      end
      default: e_valid = 1'b0;
    endcase
  end

  logic [IW+3:0] vi_wide;
  assign vi_wide = {4'b0, e_vi};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_kind <= e_kind;
    out_last <= e_last;
    if (e_last) begin
      out_voice_index  <= '0;
      out_voice_active <= 1'b0;
      out_note_number  <= '0;
      out_velocity     <= '0;
      out_channel      <= '0;
      out_volume       <= '0;
      out_pitch_bend   <= '0;
    end else begin
      out_voice_index  <= e_chan_only ? 4'd0 : vi_wide[3:0];
      out_voice_active <= e_chan_only ? 1'b0 : e_act;
      out_note_number  <= e_chan_only ? 7'd0 : e_note;
      out_velocity     <= e_chan_only ? 7'd0 : e_vel;
      out_channel      <= e_ch;
      out_volume       <= e_vol_own ? e_vol_val : vol_r[e_ch];
      out_pitch_bend   <= bend_r[e_ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      jdx_r     <= '0;
      sweep_r   <= 1'b0;
      hit_r     <= 1'b0;
      lowest_r  <= 7'd0;
      highest_r <= 7'd127;
      limit_r   <= 16'd2000;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      jdx_r   <= jdx_nxt;
      sweep_r <= sweep_nxt;
      hit_r   <= hit_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOWEST:  lowest_r  <= cfg_data[6:0];
          CFG_HIGHEST: highest_r <= cfg_data[6:0];
          CFG_TIMEOUT: limit_r   <= cfg_data;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r <= in_status_byte[3:0];
      d1_r <= in_data_one;
      d2_r <= in_data_two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        play_r[i] <= 1'b0;
        age_r[i]  <= '0;
      end
      for (int c = 0; c < 16; c++) begin
        vol_r[c]  <= 7'd127;
        bend_r[c] <= '0;
      end
    end else begin
      if (accept && (in_opcode == OP_MIDI) && (msg == MSG_BEND)) begin
        bend_r[in_status_byte[3:0]] <= {in_data_two, in_data_one} ^ BEND_CENTER;
      end
      if ((state_r == ST_CTRL) && (d1_r == CC_VOLUME)) begin
        vol_r[ch_r] <= d2_r;
      end
      if ((state_r == ST_TICK) && p && (age_r[idx_r] != 16'hFFFF)) begin
        age_r[idx_r] <= age_r[idx_r] + 16'd1;
      end
      if ((state_r == ST_ALLOFF) || free_ev) begin
        play_r[idx_r] <= 1'b0;
        age_r[idx_r]  <= '0;
      end
      if ((state_r == ST_MOVE) && pj) begin
        play_r[jdx_r] <= 1'b0;
        age_r[jdx_r]  <= '0;
        play_r[idx_r] <= 1'b1;
        age_r[idx_r]  <= '0;
      end
      if ((state_r == ST_ON_FREE) && !p) begin
        play_r[idx_r] <= 1'b1;
        age_r[idx_r]  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_MOVE) && pj) begin
      note_r[idx_r] <= note_r[jdx_r];
      vel_r[idx_r]  <= vel_r[jdx_r];
      sch_r[idx_r]  <= sch_r[jdx_r];
    end
    if ((state_r == ST_ON_FREE) && !p) begin
      note_r[idx_r] <= d1_r;
      vel_r[idx_r]  <= d2_r;
      sch_r[idx_r]  <= ch_r;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pva_checker.sv
// Port-level checker for the polyphonic voice allocator, with its bind statement.
// Depends on pva_pkg.
`default_nettype none
module pva_checker
  import pva_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_kind,
  input wire logic       out_last
);

  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_DONE)
    else $error("last result is not a done item");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transaction accepted without going busy");

  a_result_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("result issued while idle");

  a_end_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last)
    else $error("transaction ended without a done item");

endmodule

bind polyphonic_voice_allocator pva_checker u_pva_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_kind(out_kind), .out_last(out_last)
);
`default_nettype wire

### bench/polyphonic_voice_allocator_chk.sv
// Checker for the polyphonic voice allocator: watches the command, configuration and
// result ports, predicts every result from its own slot and channel tables and compares.
// Depends on pva_pkg; instantiated by polyphonic_voice_allocator_tb.
module polyphonic_voice_allocator_chk
  import pva_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_status_byte,
  input  logic [6:0]  in_data_one,
  input  logic [6:0]  in_data_two,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        out_valid,
  input  logic [1:0]  out_kind,
  input  logic [3:0]  out_voice_index,
  input  logic        out_voice_active,
  input  logic [6:0]  out_note_number,
  input  logic [6:0]  out_velocity,
  input  logic [3:0]  out_channel,
  input  logic [6:0]  out_volume,
  input  logic [13:0] out_pitch_bend,
  input  logic        out_last,
  output int          outstanding,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = NOTE_SLOTS_DEF;
  localparam int SOUNDING = (VOICES_DEF < NOTE_SLOTS_DEF) ? VOICES_DEF : NOTE_SLOTS_DEF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  vidx;
    logic        act;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [3:0]  ch;
    logic [6:0]  vol;
    logic [13:0] bend;
    logic        last;
  } voice_event_t;

  voice_event_t pending_events[$];

  logic [6:0]  low_note, high_note;
  logic [15:0] age_limit;
  logic        playing[SLOTS];
  logic [6:0]  note_of[SLOTS];
  logic [6:0]  vel_of[SLOTS];
  logic [3:0]  chan_of[SLOTS];
  logic [15:0] age_of[SLOTS];
  logic [6:0]  chan_volume[16];
  logic [13:0] chan_bend[16];

  assign outstanding = pending_events.size();

  task automatic emit(logic [1:0] kind, logic [3:0] vidx, logic act, logic [6:0] note,
                      logic [6:0] vel, logic [3:0] ch, logic last);
    voice_event_t e;
    e.kind = kind;
    e.vidx = vidx;
    e.act  = act;
    e.note = note;
    e.vel  = vel;
    e.ch   = ch;
    e.vol  = (kind == KIND_DONE) ? 7'd0 : chan_volume[ch];
    e.bend = (kind == KIND_DONE) ? 14'd0 : chan_bend[ch];
    e.last = last;
    pending_events.push_back(e);
  endtask

  task automatic emit_voice(int i);
    emit(KIND_VOICE, 4'(i), playing[i], note_of[i], vel_of[i], chan_of[i], 1'b0);
  endtask

  task automatic release_note(logic [3:0] ch, logic [6:0] note);
    for (int i = 0; i < SLOTS; i++) begin
      if (playing[i] && note_of[i] == note && chan_of[i] == ch) begin
        playing[i] = 1'b0;
        age_of[i] = '0;
        if (i < SOUNDING) begin
          emit_voice(i);
          for (int j = SOUNDING; j < SLOTS; j++) begin
            if (playing[j]) begin
              chan_of[i] = chan_of[j];
              note_of[i] = note_of[j];
              vel_of[i] = vel_of[j];
              playing[j] = 1'b0;
              age_of[j] = '0;
              playing[i] = 1'b1;
              age_of[i] = '0;
              emit_voice(i);
              break;
            end
          end
        end
        return;
      end
    end
  endtask

  task automatic allocate_note(logic [3:0] ch, logic [6:0] note, logic [6:0] vel);
    if (vel == 0) begin
      release_note(ch, note);
      return;
    end
    if (note < low_note || note > high_note) return;
    for (int i = 0; i < SLOTS; i++)
      if (playing[i] && note_of[i] == note) return;
    for (int i = 0; i < SLOTS; i++) begin
      if (!playing[i]) begin
        playing[i] = 1'b1;
        chan_of[i] = ch;
        note_of[i] = note;
        vel_of[i] = vel;
        age_of[i] = '0;
        if (i < SOUNDING) emit_voice(i);
        break;
      end
    end
    for (int i = 0; i < SLOTS; i++)
      if (playing[i] && age_of[i] >= age_limit) release_note(chan_of[i], note_of[i]);
  endtask

  task automatic predict_allocation(logic [1:0] op, logic [7:0] st, logic [6:0] d1,
                                    logic [6:0] d2);
    logic [3:0] ch;
    logic       hit;
    ch = st[3:0];
    hit = 1'b0;
    if (op == OP_TICK) begin
      for (int i = 0; i < SLOTS; i++)
        if (playing[i] && age_of[i] != 16'hFFFF) age_of[i]++;
    end else if (op == OP_ALLOFF) begin
      for (int i = 0; i < SLOTS; i++) begin
        hit = playing[i];
        playing[i] = 1'b0;
        age_of[i] = '0;
        if (hit && i < SOUNDING) emit_voice(i);
      end
    end else if (op == OP_MIDI) begin
      case (st[7:4])
        MSG_NOTE_ON:  allocate_note(ch, d1, d2);
        MSG_NOTE_OFF: release_note(ch, d1);
        MSG_CTRL: begin
          if (d1 == CC_RESET_A || d1 == CC_RESET_B || d1 == CC_RESET_C || d1 == CC_RESET_D)
            emit(KIND_TIMERS, 4'd0, 1'b0, 7'd0, 7'd0, ch, 1'b0);
          if (d1 == CC_VOLUME) begin
            chan_volume[ch] = d2;
            emit(KIND_CHANNEL, 4'd0, 1'b0, 7'd0, 7'd0, ch, 1'b0);
          end
        end
        MSG_BEND: begin
          chan_bend[ch] = {d2, d1} ^ BEND_CENTER;
          for (int i = 0; i < SOUNDING; i++)
            if (playing[i] && chan_of[i] == ch) hit = 1'b1;
          if (hit) emit(KIND_CHANNEL, 4'd0, 1'b0, 7'd0, 7'd0, ch, 1'b0);
        end
        default: ;
      endcase
    end
    emit(KIND_DONE, 4'd0, 1'b0, 7'd0, 7'd0, 4'd0, 1'b1);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    voice_event_t e;
    if (!rst_n) begin
      low_note = 7'd0;
      high_note = 7'd127;
      age_limit = 16'd2000;
      for (int i = 0; i < SLOTS; i++) begin
        playing[i] = 1'b0;
        note_of[i] = '0;
        vel_of[i] = '0;
        chan_of[i] = '0;
        age_of[i] = '0;
      end
      for (int c = 0; c < 16; c++) begin
        chan_volume[c] = 7'd127;
        chan_bend[c] = '0;
      end
      pending_events.delete();
    end else begin
      if (out_valid) begin
        if (pending_events.size() == 0) begin
          $error("result transaction with no expected result waiting");
          fail_count++;
        end else begin
          e = pending_events.pop_front();
          check_field("kind", e.kind, out_kind);
          check_field("voice_index", e.vidx, out_voice_index);
          check_field("voice_active", e.act, out_voice_active);
          check_field("note_number", e.note, out_note_number);
          check_field("velocity", e.vel, out_velocity);
          check_field("channel", e.ch, out_channel);
          check_field("volume", e.vol, out_volume);
          check_field("pitch_bend", e.bend, out_pitch_bend);
          check_field("last", e.last, out_last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOWEST:  low_note = cfg_data[6:0];
          CFG_HIGHEST: high_note = cfg_data[6:0];
          CFG_TIMEOUT: age_limit = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) predict_allocation(in_opcode, in_status_byte, in_data_one,
                                             in_data_two);
    end
  end
endmodule

### bench/polyphonic_voice_allocator_tb.sv
// Testbench top for the polyphonic voice allocator: clock, reset, configuration and
// command stimulus, verdict. Depends on pva_pkg, the allocator RTL and
// polyphonic_voice_allocator_chk, which does all prediction and comparison.
module polyphonic_voice_allocator_tb;
  import pva_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_opcode = '0;
  logic [7:0]  in_status_byte = '0;
  logic [6:0]  in_data_one = '0;
  logic [6:0]  in_data_two = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        busy, out_valid, out_voice_active, out_last;
  logic [1:0]  out_kind;
  logic [3:0]  out_voice_index, out_channel;
  logic [6:0]  out_note_number, out_velocity, out_volume;
  logic signed [13:0] out_pitch_bend;
  int          outstanding, fail_count;
  int          cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  polyphonic_voice_allocator u_top (.*);

  polyphonic_voice_allocator_chk u_chk (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_status_byte, .in_data_one,
    .in_data_two, .cfg_we, .cfg_index, .cfg_data, .out_valid, .out_kind,
    .out_voice_index, .out_voice_active, .out_note_number, .out_velocity,
    .out_channel, .out_volume, .out_pitch_bend(out_pitch_bend), .out_last,
    .outstanding, .fail_count
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic issue(logic [1:0] op, logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_status_byte <= st;
    in_data_one <= d1;
    in_data_two <= d2;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_command();
    int          r;
    logic [3:0]  ch;
    logic [6:0]  note;
    r = $urandom_range(0, 99);
    ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
    note = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'(48 + $urandom_range(0, 11));
    if (r < 40)
      issue(OP_MIDI, {MSG_NOTE_ON, ch}, note,
            ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(1, 127)));
    else if (r < 62)
      issue(OP_MIDI, {MSG_NOTE_OFF, ch}, note, 7'($urandom_range(0, 127)));
    else if (r < 78)
      issue(OP_TICK, 8'($urandom), 7'($urandom), 7'($urandom));
    else if (r < 81)
      issue(OP_ALLOFF, 8'($urandom), 7'($urandom), 7'($urandom));
    else if (r < 88) begin
      case ($urandom_range(0, 5))
        0: note = CC_VOLUME;
        1: note = CC_RESET_A;
        2: note = CC_RESET_B;
        3: note = CC_RESET_C;
        4: note = CC_RESET_D;
        default: note = 7'($urandom);
      endcase
      issue(OP_MIDI, {MSG_CTRL, ch}, note, 7'($urandom));
    end else if (r < 94)
      issue(OP_MIDI, {MSG_BEND, ch}, 7'($urandom), 7'($urandom));
    else
      issue(2'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the sounding voices and two overflow slots, then exercise release paths.
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd0}, 7'd0, 7'd127);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd15}, 7'd127, 7'd1);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd3}, 7'd60, 7'd64);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd3}, 7'd60, 7'd90);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd5}, 7'd61, 7'd100);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd6}, 7'd62, 7'd20);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd7}, 7'd63, 7'd30);
    issue(OP_MIDI, {MSG_NOTE_OFF, 4'd9}, 7'd60, 7'd0);
    issue(OP_MIDI, {MSG_NOTE_OFF, 4'd3}, 7'd60, 7'd0);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd15}, 7'd127, 7'd0);
    issue(OP_MIDI, {MSG_CTRL, 4'd5}, CC_VOLUME, 7'd0);
    issue(OP_MIDI, {MSG_CTRL, 4'd5}, CC_RESET_A, 7'd1);
    issue(OP_MIDI, {MSG_CTRL, 4'd5}, CC_RESET_B, 7'd1);
    issue(OP_MIDI, {MSG_CTRL, 4'd5}, CC_RESET_C, 7'd1);
    issue(OP_MIDI, {MSG_CTRL, 4'd5}, CC_RESET_D, 7'd1);
    issue(OP_MIDI, {MSG_CTRL, 4'd5}, 7'd1, 7'd127);
    issue(OP_MIDI, {MSG_BEND, 4'd5}, 7'd0, 7'd0);
    issue(OP_MIDI, {MSG_BEND, 4'd11}, 7'd127, 7'd127);
    issue(OP_MIDI, 8'hA5, 7'd61, 7'd127);
    issue(OP_TICK, 8'h00, 7'd0, 7'd0);
    issue(2'd3, 8'hFF, 7'd127, 7'd127);
    settle();
    write_reg(CFG_TIMEOUT, 16'd1);
    issue(OP_TICK, 8'h00, 7'd0, 7'd0);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd2}, 7'd70, 7'd50);
    issue(OP_ALLOFF, 8'h00, 7'd0, 7'd0);
    settle();
    write_reg(CFG_LOWEST, 16'd60);
    write_reg(CFG_HIGHEST, 16'd50);
    issue(OP_MIDI, {MSG_NOTE_ON, 4'd1}, 7'd55, 7'd50);

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(CFG_LOWEST, 16'd0);
          write_reg(CFG_HIGHEST, 16'd127);
          write_reg(CFG_TIMEOUT, 16'd2000);
        end
        1: begin
          write_reg(CFG_LOWEST, 16'd50);
          write_reg(CFG_HIGHEST, 16'd56);
          write_reg(CFG_TIMEOUT, 16'd3);
        end
        2: write_reg(CFG_TIMEOUT, 16'd0);
        3: begin
          write_reg(CFG_LOWEST, 16'd127);
          write_reg(CFG_HIGHEST, 16'd0);
          write_reg(CFG_TIMEOUT, 16'd65535);
        end
        default: begin
          write_reg(CFG_LOWEST, 16'd0);
          write_reg(CFG_HIGHEST, 16'd127);
          write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 12)));
        end
      endcase
      for (int k = 0; k < 51; k++) random_command();
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/pva_pkg.sv
hw/rtl/polyphonic_voice_allocator.sv
hw/rtl/pva_checker.sv
bench/polyphonic_voice_allocator_chk.sv
bench/polyphonic_voice_allocator_tb.sv
